@@ hdl/lzf_pkg.sv @@
// Shared types and constants for the LZF stream decompressor.
`default_nettype none
package lzf_pkg;

  localparam int WINDOW_BYTES     = 8192;
  localparam int ADDR_W           = $clog2(WINDOW_BYTES);
  localparam int BYTES_PER_RESULT = 8;
  localparam int DIST_W           = ADDR_W + 1;

  localparam logic [7:0] LITERAL_LIMIT = 8'd32;
  localparam logic [7:0] DIST_MASK     = 8'h1f;
  localparam logic [2:0] LONG_LEN      = 3'd7;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COPY_START,
    ST_COPY,
    ST_FINISH
  } state_t;

  // Position inside the current token.
  typedef enum logic [1:0] {
    PH_CONTROL,
    PH_LITERAL,
    PH_LENGTH,
    PH_DISTANCE
  } phase_t;

  // Status codes on the last result beat of an item.
  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_COMPLETE = 3'd1,
    STS_OVERFLOW = 3'd2,
    STS_BAD_DIST = 3'd3,
    STS_SHORT    = 3'd4,
    STS_IGNORED  = 3'd5
  } status_t;

endpackage
`default_nettype wire

@@ hdl/lzf_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module lzf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/lzf_stream_decompressor.sv @@
// LZF stream decompressor: top level with token sequencer and history RAM.
//
// Usage: compressed bytes enter one per beat on the in_valid/in_ready channel,
// with in_last on the final byte. The expected output length is written to
// limit via cfg_wr_en/cfg_wr_data; the user must do this only while the block
// is idle, which the block does not enforce. Every input beat yields one or
// more result beats on out_valid/out_ready; each carries up to eight decoded
// bytes, and run_last marks the final beat of the item, with its status.
// An accepted byte is registered, decoded in ST_DECODE and its result beat
// loaded into the output register in ST_FINISH. A back-reference first runs
// the copy loop, moving one byte per cycle through the 8 KiB history RAM
// (or a register file of the last eight bytes at distances up to eight),
// save while a full beat is handed on. One item is worked on at a time.
// Reset clears the token state, the byte count and the limit; the history
// RAM is not cleared, since only written entries are ever read.
// When the receiver stalls, the result beat waits in the output register
// and the copy loop pauses until it is taken; nothing is lost.
`default_nettype none
module lzf_stream_decompressor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_bytes,
  output logic [3:0]       out_count,
  output logic             run_last,
  output logic [2:0]       status,
  output logic [31:0]      total_out
);

  localparam int AW = lzf_pkg::ADDR_W;
  localparam int DW = lzf_pkg::DIST_W;

  lzf_pkg::state_t  state, state_next;
  lzf_pkg::phase_t  phase, phase_next;
  lzf_pkg::status_t st, st_next;

  logic [31:0] limit;
  logic [31:0] wc, wc_next;
  logic [5:0]  lit_left, lit_left_next;
  logic [7:0]  held_ctrl, held_ctrl_next;
  logic [8:0]  held_len, held_len_next;
  logic [8:0]  rem, rem_next;
  logic [DW-1:0] cp_dist, cp_dist_next;
  logic        stopped, stopped_next;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [63:0] acc, acc_next;
  logic [3:0]  acc_cnt, acc_cnt_next;
  logic [7:0]  recent [8];
  logic [7:0]  recent_next [8];

  logic        out_valid_next;
  logic [63:0] out_bytes_next;
  logic [3:0]  out_count_next;
  logic        run_last_next;
  logic [2:0]  status_next;
  logic [31:0] total_out_next;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          out_free;
  logic          near;
  logic [7:0]    copy_byte;
  logic [DW-1:0] dist_m1;
  logic [DW-1:0] dist_calc;
  logic [32:0]   lit_end, ref_end;
  logic          accept;

  assign in_ready = (state == lzf_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign dist_m1  = cp_dist - DW'(1);
  assign near     = (cp_dist <= DW'(lzf_pkg::BYTES_PER_RESULT));
  assign copy_byte = near ? recent[dist_m1[2:0]] : ram_rdata;
  assign dist_calc = DW'({held_ctrl & lzf_pkg::DIST_MASK, byte_r}) + DW'(1);
  assign lit_end  = {1'b0, wc} + 33'({byte_r[4:0]} + 6'd1);
  assign ref_end  = {1'b0, wc} + 33'(held_len);

  lzf_ram #(.WIDTH(8), .DEPTH(lzf_pkg::WINDOW_BYTES)) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next-state logic for the sequencer, token state and output register.
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    st_next        = st;
    wc_next        = wc;
    lit_left_next  = lit_left;
    held_ctrl_next = held_ctrl;
    held_len_next  = held_len;
    rem_next       = rem;
    cp_dist_next   = cp_dist;
    stopped_next   = stopped;
    acc_next       = acc;
    acc_cnt_next   = acc_cnt;
    for (int i = 0; i < 8; i++) begin
      recent_next[i] = recent[i];
    end
    out_valid_next = out_valid && !out_ready;
    out_bytes_next = out_bytes;
    out_count_next = out_count;
    run_last_next  = run_last;
    status_next    = status;
    total_out_next = total_out;
    ram_we         = 1'b0;
    ram_waddr      = wc[AW-1:0];
    ram_wdata      = copy_byte;
    ram_re         = 1'b0;
    ram_raddr      = AW'(wc - 32'(cp_dist));

    unique case (state)
      lzf_pkg::ST_IDLE: begin
        if (accept) begin
          st_next      = lzf_pkg::STS_OK;
          acc_next     = '0;
          acc_cnt_next = '0;
          state_next   = lzf_pkg::ST_DECODE;
        end
      end

      lzf_pkg::ST_DECODE: begin
        state_next = lzf_pkg::ST_FINISH;
        if (stopped) begin
          st_next = lzf_pkg::STS_IGNORED;
        end else begin
          unique case (phase)
            lzf_pkg::PH_CONTROL: begin
              if (wc >= limit) begin
                st_next = lzf_pkg::STS_COMPLETE;
              end else if (byte_r < lzf_pkg::LITERAL_LIMIT) begin
                if (lit_end > {1'b0, limit}) begin
                  st_next = lzf_pkg::STS_OVERFLOW;
                end else begin
                  lit_left_next = {1'b0, byte_r[4:0]} + 6'd1;
                  phase_next    = lzf_pkg::PH_LITERAL;
                end
              end else begin
                held_ctrl_next = byte_r;
                if (byte_r[7:5] == lzf_pkg::LONG_LEN) begin
                  phase_next = lzf_pkg::PH_LENGTH;
                end else begin
                  held_len_next = 9'(byte_r[7:5]) + 9'd2;
                  phase_next    = lzf_pkg::PH_DISTANCE;
                end
              end
            end
            lzf_pkg::PH_LITERAL: begin
              // Literal byte goes into an empty accumulator.
              ram_we        = 1'b1;
              ram_wdata     = byte_r;
              wc_next       = wc + 32'd1;
              acc_next      = {56'd0, byte_r};
              acc_cnt_next  = 4'd1;
              recent_next[0] = byte_r;
              for (int i = 1; i < 8; i++) begin
                recent_next[i] = recent[i-1];
              end
              if (lit_left > 6'd0) begin
                lit_left_next = lit_left - 6'd1;
              end
              if (lit_left <= 6'd1) begin
                phase_next = lzf_pkg::PH_CONTROL;
              end
            end
            lzf_pkg::PH_LENGTH: begin
              held_len_next = 9'(byte_r) + 9'd9;
              phase_next    = lzf_pkg::PH_DISTANCE;
            end
            lzf_pkg::PH_DISTANCE: begin
              phase_next   = lzf_pkg::PH_CONTROL;
              cp_dist_next = dist_calc;
              rem_next     = held_len;
              if (ref_end > {1'b0, limit}) begin
                st_next = lzf_pkg::STS_OVERFLOW;
              end else if (32'(dist_calc) > wc) begin
                st_next = lzf_pkg::STS_BAD_DIST;
              end else begin
                state_next = lzf_pkg::ST_COPY_START;
              end
            end
            default: begin
              st_next = lzf_pkg::STS_OK;
            end
          endcase
        end
      end

      lzf_pkg::ST_COPY_START: begin
        // Fetch the first source byte of the back-reference.
        ram_re     = 1'b1;
        ram_raddr  = AW'(wc - 32'(cp_dist));
        state_next = lzf_pkg::ST_COPY;
      end

      lzf_pkg::ST_COPY: begin
        if (acc_cnt == 4'(lzf_pkg::BYTES_PER_RESULT)) begin
          // Accumulator full: hand a beat to the output register first.
          if (out_free) begin
            out_valid_next = 1'b1;
            out_bytes_next = acc;
            out_count_next = acc_cnt;
            run_last_next  = 1'b0;
            status_next    = lzf_pkg::STS_OK;
            total_out_next = wc;
            acc_next       = '0;
            acc_cnt_next   = '0;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = copy_byte;
          wc_next   = wc + 32'd1;
          acc_next  = acc | (64'(copy_byte) << {acc_cnt[2:0], 3'b000});
          acc_cnt_next   = acc_cnt + 4'd1;
          recent_next[0] = copy_byte;
          for (int i = 1; i < 8; i++) begin
            recent_next[i] = recent[i-1];
          end
          rem_next = rem - 9'd1;
          if (rem == 9'd1) begin
            state_next = lzf_pkg::ST_FINISH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(wc + 32'd1 - 32'(cp_dist));
          end
        end
      end

      lzf_pkg::ST_FINISH: begin
        // Final beat of the item with its status.
        if (out_free) begin
          out_valid_next = 1'b1;
          out_bytes_next = acc;
          out_count_next = acc_cnt;
          run_last_next  = 1'b1;
          total_out_next = wc;
          status_next    = st;
          if (st == lzf_pkg::STS_OK) begin
            if (phase == lzf_pkg::PH_CONTROL && wc >= limit) begin
              status_next = lzf_pkg::STS_COMPLETE;
            end else if (last_r) begin
              status_next = lzf_pkg::STS_SHORT;
            end
          end
          if (status_next != lzf_pkg::STS_OK) begin
            stopped_next = 1'b1;
          end
          state_next = lzf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lzf_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lzf_pkg::ST_IDLE;
      phase     <= lzf_pkg::PH_CONTROL;
      wc        <= '0;
      lit_left  <= '0;
      held_ctrl <= '0;
      held_len  <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
      limit     <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      wc        <= wc_next;
      lit_left  <= lit_left_next;
      held_ctrl <= held_ctrl_next;
      held_len  <= held_len_next;
      stopped   <= stopped_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    st        <= st_next;
    rem       <= rem_next;
    cp_dist   <= cp_dist_next;
    acc       <= acc_next;
    acc_cnt   <= acc_cnt_next;
    for (int i = 0; i < 8; i++) begin
      recent[i] <= recent_next[i];
    end
    out_bytes <= out_bytes_next;
    out_count <= out_count_next;
    run_last  <= run_last_next;
    status    <= status_next;
    total_out <= total_out_next;
  end

endmodule
`default_nettype wire
